// ===== rtl/core/mcw_pkg.sv =====
// Shared types and constants for the multi-channel watchdog.
// Command and result codes, field widths and the slot memory write bundle.
// Used by multi_channel_watchdog and mcw_slot_mem.
package mcw_pkg;

    localparam int SLOT_W      = 3;
    localparam int MS_W        = 32;
    localparam int ELAPSED_W   = 16;
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    typedef enum logic [2:0] {
        CMD_REGISTER   = 3'd0,
        CMD_UNREGISTER = 3'd1,
        CMD_HEARTBEAT  = 3'd2,
        CMD_TICK       = 3'd3,
        CMD_RESTART    = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_ACK = 2'd0,
        KIND_ERR = 2'd1,
        KIND_EXP = 2'd2
    } t_kind;

    typedef struct packed {
        logic            tmo_we;
        logic            beat_we;
        logic [MS_W-1:0] tmo;
        logic [MS_W-1:0] beat;
    } t_mem_wr;

endpackage

// ===== rtl/core/mcw_slot_mem.sv =====
// Slot storage: timeout and last-heartbeat stamp of every watchdog slot.
// Two arrays sharing one read address, with a registered read.
// Depends on mcw_pkg.
module mcw_slot_mem #(
    parameter int SLOTS = 8,
    parameter int AW    = 3
) (
    input  logic                      i_clk,
    input  logic [AW-1:0]             i_rd_addr,
    output logic [mcw_pkg::MS_W-1:0]  o_rd_tmo,
    output logic [mcw_pkg::MS_W-1:0]  o_rd_beat,
    input  logic [AW-1:0]             i_wr_addr,
    input  mcw_pkg::t_mem_wr          i_wr
);
    import mcw_pkg::*;

    logic [MS_W-1:0] r_mem_tmo  [SLOTS];
    logic [MS_W-1:0] r_mem_beat [SLOTS];
    logic [MS_W-1:0] r_rd_tmo;
    logic [MS_W-1:0] r_rd_beat;

    always_ff @(posedge i_clk) begin
        if (i_wr.tmo_we) begin
            r_mem_tmo[i_wr_addr] <= i_wr.tmo;
        end
        if (i_wr.beat_we) begin
            r_mem_beat[i_wr_addr] <= i_wr.beat;
        end
        r_rd_tmo  <= r_mem_tmo[i_rd_addr];
        r_rd_beat <= r_mem_beat[i_rd_addr];
    end

    assign o_rd_tmo  = r_rd_tmo;
    assign o_rd_beat = r_rd_beat;

endmodule

// ===== rtl/core/multi_channel_watchdog.sv =====
// Multi-channel watchdog: command decoder, tick scanner and result register.
// Slot timeouts and stamps live in mcw_slot_mem; active and handler flags in flops.
// Depends on mcw_pkg and mcw_slot_mem.
//
//  channel  | direction | tuser            | tdata (lowest bit up)                       | tlast
//  s_axis   | in        | command [2:0]    | slot, timeout, has_handler, elapsed_ms,     | -
//           |           |                  | restart_ok                                  |
//  m_axis   | out       | kind [1:0]       | slot_id, overdue_ms                         | last
//
// Register, unregister, heartbeat, restart outcome: ST_EXEC loads the result beat into the
// output register once it is free, and the next command is taken after that.
// Tick: one slot read per cycle unless the scan is held; ST_FLUSH loads the final beat
// and the next command is taken once it has been loaded.
// A beat waits while the output register is full, and a held expiry holds the scan with it.
// Reset clears time, active and handler flags; slot memory is not cleared.
module multi_channel_watchdog #(
    parameter int SLOTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [55:0] i_s_axis_tdata,  // slot, timeout, has_handler, elapsed_ms, restart_ok
    input  logic [2:0]  i_s_axis_tuser,  // command
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,  // slot_id, overdue_ms
    output logic [1:0]  o_m_axis_tuser,  // kind
    output logic        o_m_axis_tlast
);
    import mcw_pkg::*;

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    t_state              r_state, n_state;
    logic [2:0]          r_cmd, n_cmd;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [MS_W-1:0]     r_tmo, n_tmo;
    logic                r_hnd, n_hnd;
    logic                r_ok, n_ok;
    logic [MS_W-1:0]     r_now, n_now;
    logic [SLOTS-1:0]    r_active, n_active;
    logic [SLOTS-1:0]    r_handler, n_handler;
    logic [AW-1:0]       r_idx, n_idx;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_pend_valid, n_pend_valid;
    logic [SLOT_W-1:0]   r_pend_id, n_pend_id;
    logic [MS_W-1:0]     r_pend_age, n_pend_age;
    logic                r_m_valid, n_m_valid;
    t_kind               r_m_kind, n_m_kind;
    logic [SLOT_W-1:0]   r_m_id, n_m_id;
    logic [MS_W-1:0]     r_m_age, n_m_age;
    logic                r_m_last, n_m_last;

    logic                s_acc;
    logic                can_push;
    logic                free_found;
    logic [AW-1:0]       free_idx;
    logic [AW-1:0]       slot_ix;
    logic                target_ok;
    logic [MS_W-1:0]     rd_tmo, rd_beat;
    logic [MS_W-1:0]     age;
    logic                is_exp;
    logic                idx_last;
    logic [AW-1:0]       wr_addr;
    t_mem_wr             mem_wr;

    mcw_slot_mem #(
        .SLOTS (SLOTS),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_addr (n_idx),
        .o_rd_tmo  (rd_tmo),
        .o_rd_beat (rd_beat),
        .i_wr_addr (wr_addr),
        .i_wr      (mem_wr)
    );

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign can_push        = !r_m_valid || i_m_axis_tready;

    assign slot_ix   = AW'(r_slot);
    assign target_ok = (32'(r_slot) < SLOTS) && r_active[slot_ix];

    // Scan data belongs to r_idx: the read address is always the next index.
    assign age      = r_now - rd_beat;
    assign is_exp   = r_active[r_idx] && (age > rd_tmo);
    assign idx_last = (r_idx == AW'(SLOTS - 1));

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                free_found = 1'b1;
                free_idx   = AW'(i);
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_slot       = r_slot;
        n_tmo        = r_tmo;
        n_hnd        = r_hnd;
        n_ok         = r_ok;
        n_now        = r_now;
        n_active     = r_active;
        n_handler    = r_handler;
        n_idx        = r_idx;
        n_cnt        = r_cnt;
        n_pend_valid = r_pend_valid;
        n_pend_id    = r_pend_id;
        n_pend_age   = r_pend_age;
        n_m_valid    = r_m_valid && !i_m_axis_tready;
        n_m_kind     = r_m_kind;
        n_m_id       = r_m_id;
        n_m_age      = r_m_age;
        n_m_last     = r_m_last;
        mem_wr       = '0;
        wr_addr      = r_idx;

        case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    n_cmd  = i_s_axis_tuser;
                    n_slot = i_s_axis_tdata[2:0];
                    n_tmo  = i_s_axis_tdata[34:3];
                    n_hnd  = i_s_axis_tdata[35];
                    n_ok   = i_s_axis_tdata[52];
                    if (i_s_axis_tuser == CMD_TICK) begin
                        n_now        = r_now + MS_W'(i_s_axis_tdata[51:36]);
                        n_idx        = '0;
                        n_cnt        = '0;
                        n_pend_valid = 1'b0;
                        n_state      = ST_SCAN;
                    end else begin
                        n_state = ST_EXEC;
                    end
                end
            end
            ST_EXEC: begin
                if (can_push) begin
                    n_m_valid = 1'b1;
                    n_m_kind  = KIND_ACK;
                    n_m_id    = '0;
                    n_m_age   = '0;
                    n_m_last  = 1'b1;
                    n_state   = ST_IDLE;
                    case (r_cmd)
                        CMD_REGISTER: begin
                            if (r_tmo == '0 || !free_found) begin
                                n_m_kind = KIND_ERR;
                            end else begin
                                n_active[free_idx]  = 1'b1;
                                n_handler[free_idx] = r_hnd;
                                wr_addr             = free_idx;
                                mem_wr.tmo_we       = 1'b1;
                                mem_wr.beat_we      = 1'b1;
                                mem_wr.tmo          = r_tmo;
                                mem_wr.beat         = r_now;
                                n_m_id              = SLOT_W'(free_idx);
                            end
                        end
                        CMD_UNREGISTER: begin
                            if (!target_ok) begin
                                n_m_kind = KIND_ERR;
                            end else begin
                                n_active[slot_ix]  = 1'b0;
                                n_handler[slot_ix] = 1'b0;
                            end
                        end
                        CMD_HEARTBEAT: begin
                            if (!target_ok) begin
                                n_m_kind = KIND_ERR;
                            end else begin
                                wr_addr        = slot_ix;
                                mem_wr.beat_we = 1'b1;
                                mem_wr.beat    = r_now;
                            end
                        end
                        CMD_RESTART: begin
                            if (!target_ok) begin
                                n_m_kind = KIND_ERR;
                            end else if (r_ok) begin
                                wr_addr        = slot_ix;
                                mem_wr.beat_we = 1'b1;
                                mem_wr.beat    = r_now;
                            end
                        end
                        default: begin
                            n_m_kind = KIND_ERR;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (is_exp) begin
                    // An earlier expiry is held back until we know it is not the final beat.
                    if (!r_pend_valid || can_push) begin
                        if (r_pend_valid) begin
                            n_m_valid = 1'b1;
                            n_m_kind  = KIND_EXP;
                            n_m_id    = r_pend_id;
                            n_m_age   = r_pend_age;
                            n_m_last  = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_id    = SLOT_W'(r_idx);
                        n_pend_age   = age;
                        n_cnt        = r_cnt + CNT_W'(1);
                        if (!r_handler[r_idx]) begin
                            mem_wr.beat_we = 1'b1;
                            mem_wr.beat    = r_now;
                        end
                        if (idx_last || r_cnt == CNT_W'(MAX_RESULTS - 1)) begin
                            n_state = ST_FLUSH;
                        end else begin
                            n_idx = r_idx + AW'(1);
                        end
                    end
                end else if (idx_last) begin
                    n_state = ST_FLUSH;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            ST_FLUSH: begin
                if (can_push) begin
                    n_m_valid    = 1'b1;
                    n_m_last     = 1'b1;
                    n_m_kind     = r_pend_valid ? KIND_EXP : KIND_ACK;
                    n_m_id       = r_pend_valid ? r_pend_id : '0;
                    n_m_age      = r_pend_valid ? r_pend_age : '0;
                    n_pend_valid = 1'b0;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_now        <= '0;
            r_active     <= '0;
            r_handler    <= '0;
            r_idx        <= '0;
            r_cnt        <= '0;
            r_pend_valid <= 1'b0;
            r_m_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_now        <= n_now;
            r_active     <= n_active;
            r_handler    <= n_handler;
            r_idx        <= n_idx;
            r_cnt        <= n_cnt;
            r_pend_valid <= n_pend_valid;
            r_m_valid    <= n_m_valid;
        end
        r_cmd      <= n_cmd;
        r_slot     <= n_slot;
        r_tmo      <= n_tmo;
        r_hnd      <= n_hnd;
        r_ok       <= n_ok;
        r_pend_id  <= n_pend_id;
        r_pend_age <= n_pend_age;
        r_m_kind   <= n_m_kind;
        r_m_id     <= n_m_id;
        r_m_age    <= n_m_age;
        r_m_last   <= n_m_last;
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {5'd0, r_m_age, r_m_id};
    assign o_m_axis_tuser  = r_m_kind;
    assign o_m_axis_tlast  = r_m_last;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_RESULTS))
        else $error("expiry count exceeds the per-tick limit");

    a_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend_valid)
        else $error("held expiry left behind after a tick");

    a_pend_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (r_cnt != '0))
        else $error("held expiry without a count");

    a_tick_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && i_s_axis_tuser == CMD_TICK) |=> (r_state == ST_SCAN && r_idx == '0))
        else $error("tick did not start its scan at slot zero");
`endif

endmodule

// ===== test/tb_multi_channel_watchdog.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for multi_channel_watchdog: directed command sequences, then
// random traffic under several idle and backpressure mixes, checked against a slot-table model.
// Depends on mcw_pkg and the multi_channel_watchdog RTL.
module tb_multi_channel_watchdog;
    import mcw_pkg::*;

    localparam int SLOTS = 8;
    localparam logic [2:0] CMD_UNDEF_FIRST = 3'd5;
    localparam logic [2:0] CMD_UNDEF_LAST  = 3'd7;

    typedef struct {
        t_kind       kind;
        logic [2:0]  slot_id;
        logic [31:0] overdue;
        logic        last;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        o_s_axis_tready;
    logic [55:0] s_data = '0;  // slot, timeout, has_handler, elapsed_ms, restart_ok
    logic [2:0]  s_user = '0;  // command
    logic        o_m_axis_tvalid;
    logic        m_ready = 1'b0;
    logic [39:0] o_m_axis_tdata;  // slot_id, overdue_ms
    logic [1:0]  o_m_axis_tuser;  // kind
    logic        o_m_axis_tlast;

    // Model of the slot table.
    logic [31:0] wd_now;
    logic        wd_active  [SLOTS];
    logic        wd_handler [SLOTS];
    logic [31:0] wd_limit   [SLOTS];
    logic [31:0] wd_stamp   [SLOTS];

    t_result pending_results[$];
    int      error_count = 0;
    int      send_idle_pct = 0;
    int      sink_stall_pct = 0;

    multi_channel_watchdog #(.SLOTS(SLOTS)) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(10_000_000);
        $display("tb_multi_channel_watchdog: done, errors");
        $finish;
    end

    function automatic void expect_result(t_kind k, logic [2:0] id, logic [31:0] age, logic fin);
        t_result r;
        r.kind = k;
        r.slot_id = id;
        r.overdue = age;
        r.last = fin;
        pending_results.push_back(r);
    endfunction

    function automatic void predict_outcome(logic [2:0] cmd, logic [2:0] slot, logic [31:0] tmo,
                                            logic hnd, logic [15:0] el, logic ok);
        int          n;
        logic [31:0] age;
        case (cmd)
            CMD_REGISTER: begin
                if (tmo == '0) begin
                    expect_result(KIND_ERR, '0, '0, 1'b1);
                    return;
                end
                for (int i = 0; i < SLOTS; i++) begin
                    if (!wd_active[i]) begin
                        wd_active[i] = 1'b1;
                        wd_handler[i] = hnd;
                        wd_limit[i] = tmo;
                        wd_stamp[i] = wd_now;
                        expect_result(KIND_ACK, 3'(i), '0, 1'b1);
                        return;
                    end
                end
                expect_result(KIND_ERR, '0, '0, 1'b1);
            end
            CMD_UNREGISTER, CMD_HEARTBEAT, CMD_RESTART: begin
                if (!wd_active[slot]) begin
                    expect_result(KIND_ERR, '0, '0, 1'b1);
                    return;
                end
                if (cmd == CMD_UNREGISTER) begin
                    wd_active[slot] = 1'b0;
                    wd_handler[slot] = 1'b0;
                end else if (cmd == CMD_HEARTBEAT || ok) begin
                    wd_stamp[slot] = wd_now;
                end
                expect_result(KIND_ACK, '0, '0, 1'b1);
            end
            CMD_TICK: begin
                wd_now = wd_now + 32'(el);
                n = 0;
                for (int i = 0; i < SLOTS && n < MAX_RESULTS; i++) begin
                    age = wd_now - wd_stamp[i];
                    if (wd_active[i] && age > wd_limit[i]) begin
                        expect_result(KIND_EXP, 3'(i), age, 1'b0);
                        n++;
                        if (!wd_handler[i])
                            wd_stamp[i] = wd_now;
                    end
                end
                if (n == 0)
                    expect_result(KIND_ACK, '0, '0, 1'b1);
                else
                    pending_results[pending_results.size() - 1].last = 1'b1;
            end
            default: expect_result(KIND_ERR, '0, '0, 1'b1);
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        $display("ERROR at %0t: %s expected %0h, got %0h", $time, what, want, got);
        error_count++;
    endtask

    // Enters and leaves at a falling edge. Valid stays high on return so that a
    // back-to-back beat needs no second assignment in the same step.
    task automatic send_beat(logic [2:0] cmd, logic [2:0] slot, logic [31:0] tmo,
                             logic hnd, logic [15:0] el, logic ok);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= cmd;
        s_data  <= {3'b000, ok, el, hnd, tmo, slot};
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        predict_outcome(cmd, slot, tmo, hnd, el, ok);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (SLOTS + 4) @(negedge i_clk);
    endtask

    always @(negedge i_clk)
        m_ready <= ($urandom_range(99) >= sink_stall_pct);

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("beat with nothing pending, kind", '0, 32'(o_m_axis_tuser));
            end else begin
                want = pending_results.pop_front();
                if (o_m_axis_tuser !== want.kind)
                    report_mismatch("kind", 32'(want.kind), 32'(o_m_axis_tuser));
                if (o_m_axis_tdata[2:0] !== want.slot_id)
                    report_mismatch("slot_id", 32'(want.slot_id), 32'(o_m_axis_tdata[2:0]));
                if (o_m_axis_tdata[34:3] !== want.overdue)
                    report_mismatch("overdue_ms", want.overdue, o_m_axis_tdata[34:3]);
                if (o_m_axis_tlast !== want.last)
                    report_mismatch("last", 32'(want.last), 32'(o_m_axis_tlast));
            end
        end
    end

    // An empty table must answer a tick with a single acknowledge.
    task automatic test_quiet_tick();
        send_beat(CMD_TICK, 3'd7, '0, 1'b1, 16'd0, 1'b1);
        wait_drained();
    endtask

    task automatic test_register_and_full_table();
        send_beat(CMD_REGISTER, 3'd0, 32'd0, 1'b0, 16'd0, 1'b0);
        send_beat(CMD_REGISTER, 3'd0, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 1'b0);
        for (int i = 1; i < SLOTS; i++)
            send_beat(CMD_REGISTER, 3'd0, 32'(i), 1'(i % 2), 16'd0, 1'b0);
        send_beat(CMD_REGISTER, 3'd0, 32'd5, 1'b0, 16'd0, 1'b0);
        wait_drained();
    endtask

    // Every slot expires on the same tick, so the tick fills the whole result budget.
    task automatic test_crowded_tick();
        send_beat(CMD_UNREGISTER, 3'd0, '0, 1'b0, 16'd0, 1'b0);
        send_beat(CMD_REGISTER, 3'd0, 32'd1, 1'b1, 16'd0, 1'b0);
        send_beat(CMD_TICK, 3'd0, '0, 1'b0, 16'hFFFF, 1'b0);
        wait_drained();
    endtask

    task automatic test_restart_outcomes();
        send_beat(CMD_RESTART, 3'd1, '0, 1'b0, 16'd0, 1'b1);
        send_beat(CMD_RESTART, 3'd3, '0, 1'b0, 16'd0, 1'b0);
        send_beat(CMD_RESTART, 3'd2, '0, 1'b0, 16'd0, 1'b1);
        send_beat(CMD_HEARTBEAT, 3'd4, '0, 1'b0, 16'd0, 1'b0);
        send_beat(CMD_TICK, 3'd0, '0, 1'b0, 16'd3, 1'b0);
        wait_drained();
    endtask

    task automatic test_bad_targets();
        send_beat(CMD_UNREGISTER, 3'd5, '0, 1'b0, 16'd0, 1'b0);
        send_beat(CMD_HEARTBEAT, 3'd5, '0, 1'b0, 16'd0, 1'b0);
        send_beat(CMD_RESTART, 3'd5, '0, 1'b0, 16'd0, 1'b1);
        send_beat(CMD_UNREGISTER, 3'd5, '0, 1'b0, 16'd0, 1'b0);
        wait_drained();
    endtask

    task automatic test_unknown_commands();
        for (int c = CMD_UNDEF_FIRST; c <= CMD_UNDEF_LAST; c++)
            send_beat(3'(c), 3'(c), 32'(c), 1'b1, 16'(c), 1'b1);
        wait_drained();
    endtask

    task automatic test_random_traffic(int count, int idle_pct, int stall_pct);
        logic [2:0]  cmd;
        logic [2:0]  slot;
        logic [31:0] tmo;
        logic [15:0] el;
        int          live[$];
        int          pick;
        send_idle_pct = idle_pct;
        sink_stall_pct = stall_pct;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            if (pick < 20)
                cmd = CMD_REGISTER;
            else if (pick < 32)
                cmd = CMD_UNREGISTER;
            else if (pick < 50)
                cmd = CMD_HEARTBEAT;
            else if (pick < 80)
                cmd = CMD_TICK;
            else if (pick < 95)
                cmd = CMD_RESTART;
            else
                cmd = 3'($urandom_range(CMD_UNDEF_FIRST, CMD_UNDEF_LAST));
            // Mostly aim at live slots so heartbeats and restarts do real work.
            live.delete();
            for (int i = 0; i < SLOTS; i++)
                if (wd_active[i])
                    live.push_back(i);
            if (live.size() > 0 && $urandom_range(99) < 80)
                slot = 3'(live[$urandom_range(live.size() - 1)]);
            else
                slot = 3'($urandom_range(SLOTS - 1));
            pick = $urandom_range(99);
            if (pick < 10)
                tmo = '0;
            else if (pick < 20)
                tmo = $urandom;
            else
                tmo = 32'($urandom_range(1, 300));
            if ($urandom_range(99) < 85)
                el = 16'($urandom_range(0, 150));
            else
                el = 16'($urandom);
            send_beat(cmd, slot, tmo, 1'($urandom), el, 1'($urandom));
            if ($urandom_range(39) == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    initial begin
        wd_now = '0;
        for (int i = 0; i < SLOTS; i++) begin
            wd_active[i] = 1'b0;
            wd_handler[i] = 1'b0;
            wd_limit[i] = '0;
            wd_stamp[i] = '0;
        end
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_quiet_tick();
        test_register_and_full_table();
        test_crowded_tick();
        test_restart_outcomes();
        test_bad_targets();
        test_unknown_commands();
        test_random_traffic(59, 0, 0);
        test_random_traffic(59, 86, 0);
        test_random_traffic(59, 0, 86);
        test_random_traffic(59, 30, 30);

        if (error_count == 0)
            $display("tb_multi_channel_watchdog: done, clean");
        else
            $display("tb_multi_channel_watchdog: done, errors");
        $finish;
    end

endmodule
